[hw/rtl/ispf_pkg.sv]
// Shared types and constants for the IMU serial frame parser.
package ispf_pkg;

  // Frame layout.
  localparam logic [7:0] HEADER_BYTE      = 8'h55;
  localparam logic [7:0] FRAME_TYPE_RESET = 8'h53;
  localparam logic [3:0] HEADER_POS       = 4'd1;
  localparam logic [3:0] BODY_START_POS   = 4'd2;
  localparam logic [3:0] VALUE_LOW_POS    = 4'd4;
  localparam logic [3:0] VALUE_HIGH_POS   = 4'd5;
  localparam logic [3:0] CHECK_POS        = 4'd10;

  // Degree conversion: raw * 180 / 256 gives Q9.7 degrees.
  localparam int                 PROD_W     = 25;
  localparam logic signed [24:0] DEG_SCALE  = 25'sd180;
  localparam int                 SCALE_SHIFT = 8;

  // Configuration register map.
  localparam int         CFG_ADDR_W     = 3;
  localparam logic [0:0] REG_FRAME_TYPE = 1'b0;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TYPE   = 2'd1,
    PH_BODY   = 2'd2
  } ispf_phase_t;

  // One result item.
  typedef struct packed {
    logic               checksum_ok;
    logic signed [15:0] raw_value;
    logic signed [15:0] scaled_degrees;
  } ispf_result_t;

endpackage

[hw/rtl/ispf_cfg.sv]
// APB-style configuration register block holding the expected frame type.
module ispf_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ispf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [7:0]                     frame_type
);
  import ispf_pkg::*;

  logic [7:0] frame_type_r;
  logic [7:0] frame_type_nxt;
  logic       sel_type;

  // Only the word at byte address 0 holds a register.
  assign sel_type = (paddr[CFG_ADDR_W-1] == REG_FRAME_TYPE);

  // Write on the access phase of a selected write.
  always_comb begin
    frame_type_nxt = frame_type_r;
    if (psel && penable && pwrite && sel_type) begin
      frame_type_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_type_r <= FRAME_TYPE_RESET;
    end else begin
      frame_type_r <= frame_type_nxt;
    end
  end

  // Read data and a port that never waits.
  assign prdata     = sel_type ? {24'd0, frame_type_r} : 32'd0;
  assign pready     = 1'b1;
  assign frame_type = frame_type_r;

endmodule

[hw/rtl/ispf_parser.sv]
// Frame parser state and the result computed from the checksum byte.
module ispf_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             frame_type,
  output logic                   res_valid,
  output ispf_pkg::ispf_result_t res
);
  import ispf_pkg::*;

  ispf_phase_t        phase_r, phase_nxt;
  logic [3:0]         pos_r, pos_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [7:0]         low_r, low_nxt;
  logic [7:0]         high_r, high_nxt;
  logic signed [15:0] raw;
  logic signed [PROD_W-1:0] prod;

  // Next state for one accepted byte.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    res_valid = 1'b0;
    if (accept) begin
      case (phase_r)
        PH_TYPE: begin
          if (rx_byte == frame_type) begin
            sum_nxt   = sum_r + rx_byte;
            pos_nxt   = BODY_START_POS;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (pos_r < CHECK_POS) begin
            sum_nxt = sum_r + rx_byte;
            if (pos_r == VALUE_LOW_POS) begin
              low_nxt = rx_byte;
            end else if (pos_r == VALUE_HIGH_POS) begin
              high_nxt = rx_byte;
            end
            pos_nxt = pos_r + 4'd1;
          end else begin
            res_valid = 1'b1;
            phase_nxt = PH_HEADER;
            pos_nxt   = 4'd0;
            sum_nxt   = 8'd0;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          if (rx_byte == HEADER_BYTE) begin
            sum_nxt   = HEADER_BYTE;
            pos_nxt   = HEADER_POS;
            phase_nxt = PH_TYPE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= 4'd0;
      sum_r   <= 8'd0;
      low_r   <= 8'd0;
      high_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
    end
  end

  // Result fields; the arithmetic shift of the product floors the scaled value.
  assign raw  = $signed({high_r, low_r});
  assign prod = PROD_W'(raw) * DEG_SCALE;

  assign res.checksum_ok    = (sum_r == rx_byte);
  assign res.raw_value      = raw;
  assign res.scaled_degrees = prod[SCALE_SHIFT+15:SCALE_SHIFT];

endmodule

[hw/rtl/ispf_out_buf.sv]
// Output register with a skid entry so input bytes keep flowing under a stall.
module ispf_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ispf_pkg::ispf_result_t push_data,
  input  logic                   out_stall,
  output logic                   out_valid,
  output ispf_pkg::ispf_result_t out_data,
  output logic                   full
);
  import ispf_pkg::*;

  logic         main_valid_r, main_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  ispf_result_t main_r, main_nxt;
  ispf_result_t skid_r, skid_nxt;
  logic         pop;

  assign pop = main_valid_r && !out_stall;

  // Refill the output register from the skid entry first, then from new results.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign full      = skid_valid_r;

endmodule

[hw/rtl/imu_serial_frame_parser_top.sv]
// Top level of the IMU serial frame parser.
//
// The input channel takes one received serial byte per item (in_valid,
// in_stall, in_rx_byte). The block finds 11-byte frames: header 0x55, the
// byte held in the frame type register, eight data bytes and a checksum.
// On the checksum byte it sends one result item on the output channel
// (out_valid, out_stall): the checksum flag, the signed value in frame
// bytes 4 and 5, and that value in Q9.7 degrees. Other bytes give no item.
// The frame type register (reset 0x53) sits at byte address 0 of the
// APB-style port; pready is always high.
// A byte is taken every cycle while in_stall is low. A result item is written
// to the output register, or to the skid entry behind a stalled result.
// When the receiver stalls, one further result fits in a skid entry; once
// that entry is occupied, in_stall stays high until the receiver takes the
// result in the output register.
// Synchronous reset clears the parser to wait for a header, empties the
// output stage and restores the frame type register.
module imu_serial_frame_parser_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_checksum_ok,
  output logic signed [15:0]             out_raw_value,
  output logic signed [15:0]             out_scaled_degrees,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ispf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ispf_pkg::*;

  logic         in_accept;
  logic [7:0]   frame_type;
  logic         res_valid;
  ispf_result_t res;
  ispf_result_t out_data;
  logic         buf_full;

  // Configuration register.
  ispf_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .frame_type (frame_type)
  );

  assign in_accept = in_valid && !in_stall;

  // Frame parser.
  ispf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .rx_byte    (in_rx_byte),
    .frame_type (frame_type),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output register and skid entry.
  ispf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

  assign in_stall           = buf_full;
  assign out_checksum_ok    = out_data.checksum_ok;
  assign out_raw_value      = out_data.raw_value;
  assign out_scaled_degrees = out_data.scaled_degrees;

endmodule

[hw/rtl/ispf_checker.sv]
// Port-level checks for the IMU serial frame parser, bound to the top level.
module ispf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [7:0]                     in_rx_byte,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_checksum_ok,
  input logic signed [15:0]             out_raw_value,
  input logic signed [15:0]             out_scaled_degrees,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [ispf_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           pready
);
  import ispf_pkg::*;

  logic signed [PROD_W-1:0] chk_prod;

  assign chk_prod = PROD_W'(out_raw_value) * DEG_SCALE;

  // The input only stalls while a result is held at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall high with no result at the output");

  // The input stall only starts after the output was stalled with a result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without a stalled output");

  // The degree field always follows from the raw field.
  a_scaled_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_scaled_degrees == chk_prod[SCALE_SHIFT+15:SCALE_SHIFT]))
    else $error("scaled_degrees does not match raw_value");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_checksum_ok)
      && $stable(out_raw_value) && $stable(out_scaled_degrees))
    else $error("stalled result changed or dropped");

endmodule

bind imu_serial_frame_parser_top ispf_checker u_ispf_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the IMU serial frame parser top level.
module testbench;
  import ispf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_ADDR_W-1:0] FRAME_TYPE_ADDR = CFG_ADDR_W'(int'(REG_FRAME_TYPE) * 4);
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR   = CFG_ADDR_W'(4);
  localparam int FRAME_BYTES = 11;

  // Frame predictor and store of expected result items.
  class frame_scoreboard;
    logic [7:0]   frame_type;
    ispf_phase_t  phase;
    logic [3:0]   pos;
    logic [7:0]   sum;
    logic [7:0]   value_lo;
    logic [7:0]   value_hi;
    ispf_result_t expected_q[$];
    int           mismatches;

    function new();
      frame_type = FRAME_TYPE_RESET;
      phase      = PH_HEADER;
      pos        = '0;
      sum        = '0;
      value_lo   = '0;
      value_hi   = '0;
      mismatches = 0;
    endfunction

    function void set_frame_type(logic [7:0] v);
      frame_type = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Degrees in Q9.7: floor(raw * 180 / 256), done with an arithmetic shift.
    function logic signed [15:0] to_degrees(logic signed [15:0] raw);
      logic signed [31:0] prod;
      prod = raw * 32'sd180;
      return prod[23:8];
    endfunction

    // Advance the parser by one accepted byte; a checksum byte yields a result.
    function void take_byte(logic [7:0] b);
      ispf_result_t r;
      case (phase)
        PH_TYPE: begin
          if (b == frame_type) begin
            sum   = sum + b;
            pos   = BODY_START_POS;
            phase = PH_BODY;
          end
        end
        PH_BODY: begin
          if (pos < CHECK_POS) begin
            sum = sum + b;
            if (pos == VALUE_LOW_POS) value_lo = b;
            else if (pos == VALUE_HIGH_POS) value_hi = b;
            pos = pos + 4'd1;
          end else begin
            r.checksum_ok    = (sum == b);
            r.raw_value      = {value_hi, value_lo};
            r.scaled_degrees = to_degrees({value_hi, value_lo});
            expected_q.push_back(r);
            phase = PH_HEADER;
            pos   = '0;
            sum   = '0;
          end
        end
        default: begin
          phase = PH_HEADER;
          if (b == HEADER_BYTE) begin
            sum   = HEADER_BYTE;
            pos   = HEADER_POS;
            phase = PH_TYPE;
          end
        end
      endcase
    endfunction

    // Compare one accepted result item with the oldest expectation.
    function void check_result(logic ok, logic signed [15:0] raw, logic signed [15:0] deg);
      ispf_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result item: ok=%0b raw=%0d deg=%0d", ok, raw, deg);
        return;
      end
      e = expected_q.pop_front();
      if (e.checksum_ok !== ok || e.raw_value !== raw || e.scaled_degrees !== deg) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected ok=%0b raw=%0d deg=%0d, got ok=%0b raw=%0d deg=%0d",
                   e.checksum_ok, e.raw_value, e.scaled_degrees, ok, raw, deg);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_checksum_ok;
  logic signed [15:0]    out_raw_value;
  logic signed [15:0]    out_scaled_degrees;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  frame_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int bytes_sent     = 0;
  int cycle_count    = 0;

  imu_serial_frame_parser_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_checksum_ok    (out_checksum_ok),
    .out_raw_value      (out_raw_value),
    .out_scaled_degrees (out_scaled_degrees),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: a long hold-off when requested, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every accepted result item goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_checksum_ok, out_raw_value, out_scaled_degrees);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles first, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  // Send a frame; junk bytes between header and type byte must be skipped.
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] value,
                            input bit bad_sum, input int junk);
    logic [7:0] fb [FRAME_BYTES];
    logic [7:0] s;
    logic [7:0] j;
    fb[0] = HEADER_BYTE;
    fb[1] = ftype;
    for (int i = 2; i < FRAME_BYTES - 1; i++) fb[i] = 8'($urandom);
    fb[VALUE_LOW_POS]  = value[7:0];
    fb[VALUE_HIGH_POS] = value[15:8];
    s = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) s = s + fb[i];
    fb[CHECK_POS] = bad_sum ? (s ^ 8'($urandom_range(255, 1))) : s;
    send_byte(fb[0]);
    for (int k = 0; k < junk; k++) begin
      j = $urandom_range(1) ? HEADER_BYTE : 8'($urandom);
      while (j == ftype) j = 8'($urandom);
      send_byte(j);
    end
    for (int i = 1; i < FRAME_BYTES; i++) send_byte(fb[i]);
  endtask

  // Values lean toward the extremes of the signed range, minus one and zero.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly good frames with random content, plus bad sums, noise and junk.
  task automatic run_traffic(input int n);
    int target;
    int pick;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_frame(sb.frame_type, pick_value(), 1'b0, 0);
      end else if (pick < 80) begin
        send_frame(sb.frame_type, pick_value(), 1'b1, 0);
      end else if (pick < 90) begin
        send_frame(sb.frame_type, pick_value(), 1'($urandom_range(1)), $urandom_range(4, 1));
      end else begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
      end
    end
  endtask

  // Stop sending and wait until every expected item has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Register write with setup and access phases; upper data bits are random and must not matter.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == FRAME_TYPE_ADDR) sb.set_frame_type(val);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: noise before a header, a frame whose type byte is preceded by
    // ignored bytes (possibly a repeated header among them), and a bad checksum.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_frame(FRAME_TYPE_RESET, 16'h8000, 1'b0, 2);
    send_frame(FRAME_TYPE_RESET, 16'h7FFF, 1'b1, 0);

    // Rate frames with no idling, then a long receiver hold-off that fills
    // the output stage, then a sender pause until everything has drained.
    wait_drained();
    cfg_write(FRAME_TYPE_ADDR, 8'h52);
    run_traffic(100);
    hold_left <= 400;
    run_traffic(66);
    wait_drained();
    run_traffic(40);

    // Type zero; a write to an unmapped address must leave it in place.
    wait_drained();
    cfg_write(FRAME_TYPE_ADDR, 8'h00);
    cfg_write(UNMAPPED_ADDR, 8'($urandom_range(255, 1)));
    send_idle_pct = 79;
    run_traffic(140);

    // Type all ones with a mostly stalled receiver.
    wait_drained();
    cfg_write(FRAME_TYPE_ADDR, 8'hFF);
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    run_traffic(140);

    // Random type with light idling on both sides.
    wait_drained();
    cfg_write(FRAME_TYPE_ADDR, 8'($urandom));
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    run_traffic(130);

    // Let the last items out, then give the verdict.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
